// ===== rtl/core/lralu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lralu_pkg;

    // operation codes
    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_ADDHL = 5'd10,
        OP_ADDSP = 5'd11,
        OP_INC16 = 5'd12,
        OP_DEC16 = 5'd13,
        OP_RLC   = 5'd14,
        OP_RRC   = 5'd15,
        OP_RL    = 5'd16,
        OP_RR    = 5'd17,
        OP_SLA   = 5'd18,
        OP_SRA   = 5'd19,
        OP_SWAP  = 5'd20,
        OP_SRL   = 5'd21,
        OP_BIT   = 5'd22,
        OP_RES   = 5'd23,
        OP_SET   = 5'd24
    } t_op;

    // flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

endpackage

`default_nettype wire

// ===== rtl/core/lr35902_alu_with_flags_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 8-bit cpu alu with z/n/h/c flags. each item carries an opcode, the accumulator,
// the flags, an 8-bit operand, a 16-bit register, a 16-bit addend, a signed
// offset and a bit index, and returns exactly one result item with the new
// accumulator, 8-bit register, 16-bit register and flags. the block takes one
// item every cycle while o_stall is low; a result is offered on the output once
// its item has moved from the input register into the result register. the item
// passes through two register stages, the input register and then the result
// register, around a single pass of alu logic. a stalled result holds in the
// result register while the input register can still take one more item;
// o_stall rises only when both are full and i_stall is high. unused opcodes
// pass every field through unchanged.
module lr35902_alu_with_flags_core
    import lralu_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    // input channel
    input  wire               i_valid,
    output logic              o_stall,
    input  wire  [4:0]        i_kind,
    input  wire  [7:0]        i_acc_in,
    input  wire  [3:0]        i_flags_in,
    input  wire  [7:0]        i_operand,
    input  wire  [15:0]       i_wide_in,
    input  wire  [15:0]       i_wide_addend,
    input  wire  signed [7:0] i_offset,
    input  wire  [2:0]        i_bit_pos,
    // result channel
    output logic              o_valid,
    input  wire               i_stall,
    output logic [7:0]        o_acc_out,
    output logic [7:0]        o_reg_out,
    output logic [15:0]       o_wide_out,
    output logic [3:0]        o_flags_out
);

    // input register
    logic        r_in_valid;
    logic [4:0]  r_kind;
    logic [7:0]  r_acc;
    logic [3:0]  r_flags;
    logic [7:0]  r_opnd;
    logic [15:0] r_wide;
    logic [15:0] r_addend;
    logic [7:0]  r_offset;
    logic [2:0]  r_pos;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_acc_out;
    logic [7:0]  r_reg_out;
    logic [15:0] r_wide_out;
    logic [3:0]  r_flags_out;

    logic        out_move;
    logic        in_move;

    // result register loads when empty or being drained
    assign out_move = !r_out_valid || !i_stall;
    // input register loads when empty or its item moves on
    assign in_move  = !r_in_valid || out_move;

    assign o_stall     = !in_move;
    assign o_valid     = r_out_valid;
    assign o_acc_out   = r_acc_out;
    assign o_reg_out   = r_reg_out;
    assign o_wide_out  = r_wide_out;
    assign o_flags_out = r_flags_out;

    // alu datapath
    logic [7:0]  n_acc_out;
    logic [7:0]  n_reg_out;
    logic [15:0] n_wide_out;
    logic [3:0]  n_flags_out;

    logic        cin;
    logic        carry_use;
    logic [8:0]  add9;
    logic [4:0]  addh5;
    logic [8:0]  sub9;
    logic [4:0]  subh5;
    logic [7:0]  and8;
    logic [7:0]  or8;
    logic [7:0]  xor8;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] hl17;
    logic [12:0] hl13;
    logic [15:0] sp16;
    logic [4:0]  sph5;
    logic [8:0]  spc9;
    logic [7:0]  shift8;
    logic        shift_c;
    logic [7:0]  bit_mask;

    always_comb begin
        cin       = r_flags[FLAG_C];
        carry_use = ((r_kind == OP_ADC) || (r_kind == OP_SBC)) ? cin : 1'b0;

        // 8-bit add and subtract with the carry folded in
        add9  = {1'b0, r_acc} + {1'b0, r_opnd} + {8'd0, carry_use};
        addh5 = {1'b0, r_acc[3:0]} + {1'b0, r_opnd[3:0]} + {4'd0, carry_use};
        sub9  = {1'b0, r_acc} - {1'b0, r_opnd} - {8'd0, carry_use};
        subh5 = {1'b0, r_acc[3:0]} - {1'b0, r_opnd[3:0]} - {4'd0, carry_use};

        and8 = r_acc & r_opnd;
        or8  = r_acc | r_opnd;
        xor8 = r_acc ^ r_opnd;
        inc8 = r_opnd + 8'd1;
        dec8 = r_opnd - 8'd1;

        // 16-bit adds
        hl17 = {1'b0, r_wide} + {1'b0, r_addend};
        hl13 = {1'b0, r_wide[11:0]} + {1'b0, r_addend[11:0]};
        sp16 = r_wide + {{8{r_offset[7]}}, r_offset};
        sph5 = {1'b0, r_wide[3:0]} + {1'b0, r_offset[3:0]};
        spc9 = {1'b0, r_wide[7:0]} + {1'b0, r_offset};

        bit_mask = 8'd1 << r_pos;

        // cb rotate and shift unit
        shift8  = r_opnd;
        shift_c = 1'b0;
        case (t_op'(r_kind))
            OP_RLC: begin
                shift8  = {r_opnd[6:0], r_opnd[7]};
                shift_c = r_opnd[7];
            end
            OP_RRC: begin
                shift8  = {r_opnd[0], r_opnd[7:1]};
                shift_c = r_opnd[0];
            end
            OP_RL: begin
                shift8  = {r_opnd[6:0], cin};
                shift_c = r_opnd[7];
            end
            OP_RR: begin
                shift8  = {cin, r_opnd[7:1]};
                shift_c = r_opnd[0];
            end
            OP_SLA: begin
                shift8  = {r_opnd[6:0], 1'b0};
                shift_c = r_opnd[7];
            end
            OP_SRA: begin
                shift8  = {r_opnd[7], r_opnd[7:1]};
                shift_c = r_opnd[0];
            end
            OP_SWAP: begin
                shift8  = {r_opnd[3:0], r_opnd[7:4]};
                shift_c = 1'b0;
            end
            OP_SRL: begin
                shift8  = {1'b0, r_opnd[7:1]};
                shift_c = r_opnd[0];
            end
            default: begin
                shift8  = r_opnd;
                shift_c = 1'b0;
            end
        endcase

        // result selection, untouched fields pass through
        n_acc_out   = r_acc;
        n_reg_out   = r_opnd;
        n_wide_out  = r_wide;
        n_flags_out = r_flags;
        case (t_op'(r_kind))
            OP_ADD, OP_ADC: begin
                n_acc_out   = add9[7:0];
                n_flags_out = {add9[7:0] == 8'd0, 1'b0, addh5[4], add9[8]};
            end
            OP_SUB, OP_SBC: begin
                n_acc_out   = sub9[7:0];
                n_flags_out = {sub9[7:0] == 8'd0, 1'b1, subh5[4], sub9[8]};
            end
            OP_CP: begin
                n_flags_out = {sub9[7:0] == 8'd0, 1'b1, subh5[4], sub9[8]};
            end
            OP_AND: begin
                n_acc_out   = and8;
                n_flags_out = {and8 == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_OR: begin
                n_acc_out   = or8;
                n_flags_out = {or8 == 8'd0, 3'b000};
            end
            OP_XOR: begin
                n_acc_out   = xor8;
                n_flags_out = {xor8 == 8'd0, 3'b000};
            end
            OP_INC: begin
                n_reg_out   = inc8;
                n_flags_out = {inc8 == 8'd0, 1'b0, r_opnd[3:0] == 4'hF, cin};
            end
            OP_DEC: begin
                n_reg_out   = dec8;
                n_flags_out = {dec8 == 8'd0, 1'b1, r_opnd[3:0] == 4'h0, cin};
            end
            OP_ADDHL: begin
                n_wide_out  = hl17[15:0];
                n_flags_out = {r_flags[FLAG_Z], 1'b0, hl13[12], hl17[16]};
            end
            OP_ADDSP: begin
                n_wide_out  = sp16;
                n_flags_out = {2'b00, sph5[4], spc9[8]};
            end
            OP_INC16: begin
                n_wide_out = r_wide + 16'd1;
            end
            OP_DEC16: begin
                n_wide_out = r_wide - 16'd1;
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
                n_reg_out   = shift8;
                n_flags_out = {shift8 == 8'd0, 2'b00, shift_c};
            end
            OP_BIT: begin
                // z set when the tested bit is clear
                n_flags_out = {(r_opnd & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
            end
            OP_RES: begin
                n_reg_out = r_opnd & ~bit_mask;
            end
            OP_SET: begin
                n_reg_out = r_opnd | bit_mask;
            end
            default: begin
                n_acc_out   = r_acc;
                n_reg_out   = r_opnd;
                n_wide_out  = r_wide;
                n_flags_out = r_flags;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_move) begin
            r_in_valid <= i_valid;
        end
        if (in_move && i_valid) begin
            r_kind   <= i_kind;
            r_acc    <= i_acc_in;
            r_flags  <= i_flags_in;
            r_opnd   <= i_operand;
            r_wide   <= i_wide_in;
            r_addend <= i_wide_addend;
            r_offset <= i_offset;
            r_pos    <= i_bit_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_move) begin
            r_out_valid <= r_in_valid;
        end
        if (out_move && r_in_valid) begin
            r_acc_out   <= n_acc_out;
            r_reg_out   <= n_reg_out;
            r_wide_out  <= n_wide_out;
            r_flags_out <= n_flags_out;
        end
    end

    // a held item is never dropped from the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_move) |=> r_in_valid)
        else $error("input register lost an item while blocked");

    // an item in the input register reaches the result register when it moves
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_move) |=> r_out_valid)
        else $error("item vanished between input and result register");

    // a drained result with nothing behind it leaves the output empty
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && r_out_valid && !i_stall) |=> !r_out_valid)
        else $error("result appeared with no item behind it");

    // unused opcodes pass the accumulator and flags through
    a_unused_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_move && (r_kind > OP_SET))
        |=> ((r_acc_out == $past(r_acc)) && (r_flags_out == $past(r_flags))))
        else $error("unused opcode changed the accumulator or flags");

endmodule

`default_nettype wire
